// ===== rtl/hue_wheel_pattern_generator_unit_defines.svh =====
// assertion macros for the hue wheel pattern generator
`ifndef HUE_WHEEL_PATTERN_GENERATOR_UNIT_DEFINES_SVH
`define HUE_WHEEL_PATTERN_GENERATOR_UNIT_DEFINES_SVH

// implication checked on every clock edge outside reset
`define HWP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication checked outside reset
`define HWP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/hwp_pkg.sv =====
// ----------------------------------------------------------------------------
// hwp_pkg
// shared types, constants and tables of the hue wheel pattern generator
// ----------------------------------------------------------------------------
`default_nettype none
package hwp_pkg;

  localparam int DimW      = 13;
  localparam int CntW      = 12;
  localparam int MaxDim    = 4096;
  localparam int AngBits   = 12;
  localparam int QSteps    = 1 << (AngBits - 2);
  localparam int QBits     = AngBits - 2;
  localparam int Fine      = 3 << (AngBits + 1);
  localparam int PhW       = 15;
  localparam int ProdW     = 26;
  localparam int BndW      = 31;
  // channel levels of the even phases of a quarter turn
  localparam int ChanDepth = Fine / 8 + 1;
  localparam int ChanIdxW  = 12;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_FETCH,
    ST_STEP,
    ST_RED,
    ST_GREEN,
    ST_BLUE,
    ST_OUT
  } hwp_state_t;

  // color channel, also the number of thirds of a turn added to the hue
  typedef enum logic [1:0] {
    CH_RED,
    CH_GREEN,
    CH_BLUE
  } hwp_chan_t;

  typedef struct packed {
    logic      load;
    logic      setup;
    logic      fetch;
    logic      step;
    logic      chan_rd;
    hwp_chan_t chan_sel;
    logic      keep_red;
    logic      keep_green;
    logic      publish;
  } hwp_cmd_t;

  typedef struct packed {
    logic search_done;
  } hwp_status_t;

  // sine in Q30 of a phase in [0, Fine/4], taylor series up to the 17th power
  function automatic logic [BndW-1:0] quarter_sine(input int unsigned p);
    logic [63:0] x, x2, term;
    longint s;
    x = (64'(p) * 64'd6746518852) / 64'(Fine);
    x2 = (x * x) >> 30;
    term = x;
    s = longint'(x);
    for (int i = 1; i <= 8; i++) begin
      term = ((term * x2) >> 30) / 64'((2 * i) * (2 * i + 1));
      if (i % 2 == 1) s = s - longint'(term);
      else s = s + longint'(term);
    end
    if (s < 0) s = 0;
    if (s > (longint'(1) << 30)) s = longint'(1) << 30;
    return BndW'(s);
  endfunction

  // channel level of a phase in [0, Fine/4]
  function automatic logic [7:0] chan_level(input int unsigned p);
    logic [63:0] v;
    v = (64'(quarter_sine(p)) * 64'd255 + 64'd16384) >> 30;
    return (v > 64'd255) ? 8'd255 : v[7:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/hue_wheel_pattern_generator_unit.sv =====
// ----------------------------------------------------------------------------
// hue_wheel_pattern_generator_unit
// rgba color wheel test pattern generator in raster order
// ----------------------------------------------------------------------------
// Each input transaction yields one pixel. After acceptance it passes a setup
// state, a 10 or 11 step binary search for the hue angle, each step a
// boundary table read and then a compare, a check that sees the search end,
// three channel table reads and a state that loads the result register. The
// next transaction is accepted from the cycle after the result is loaded,
// even while that result still waits; a pixel only stalls at the end if the
// one before it has not been taken yet. No new transaction is accepted while
// a pixel is still in the search or the channel lookup.
`default_nettype none
`include "hue_wheel_pattern_generator_unit_defines.svh"
module hue_wheel_pattern_generator_unit import hwp_pkg::*; (
  input  wire         clk,
  input  wire         rst,
  input  wire         cfg_we,
  input  wire         cfg_index,
  input  wire [12:0]  cfg_data,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [7:0]  s_tdata,   // [0] start_frame
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [31:0] m_tdata,   // red, green, blue, alpha
  output logic        m_tlast,   // end_of_line
  output logic        m_tuser    // end_of_frame
);

  localparam logic RegWidth = 1'b0;

  logic [DimW-1:0] frame_width, frame_height;
  hwp_cmd_t cmd;
  hwp_status_t status;
  logic busy;
  logic [7:0] red, green, blue;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width <= DimW'(640);
      frame_height <= DimW'(480);
    end else if (cfg_we) begin
      if (cfg_index == RegWidth) frame_width <= cfg_data;
      else frame_height <= cfg_data;
    end
  end

  assign s_tready = !busy;

  hwp_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_take(s_tvalid && s_tready),
    .out_taken(m_tvalid && m_tready),
    .status(status), .cmd(cmd), .busy(busy), .out_valid(m_tvalid)
  );

  hwp_datapath u_dp (
    .clk(clk), .rst(rst),
    .frame_width(frame_width), .frame_height(frame_height),
    .start_frame(s_tdata[0]), .cmd(cmd), .status(status),
    .red(red), .green(green), .blue(blue),
    .end_of_line(m_tlast), .end_of_frame(m_tuser)
  );

  assign m_tdata = {8'hFF, blue, green, red};

  `HWP_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while waiting")
  `HWP_ASSERT_IMP(a_eof_eol, m_tvalid && m_tuser, m_tlast, "end of frame without end of line")
  `HWP_ASSERT_NEXT(a_accept_then_busy, s_tvalid && s_tready, !s_tready, "second accept")

endmodule
`default_nettype wire

// ===== rtl/hwp_ctrl.sv =====
// ----------------------------------------------------------------------------
// hwp_ctrl
// sequencer: setup, binary search for the hue, color lookup, result register
// ----------------------------------------------------------------------------
`default_nettype none
module hwp_ctrl import hwp_pkg::*; (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_take,
  input  wire         out_taken,
  input  hwp_status_t status,
  output hwp_cmd_t    cmd,
  output logic        busy,
  output logic        out_valid
);

  hwp_state_t state, state_next;
  logic       out_free;

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // result register occupancy
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.publish) out_valid <= 1'b1;
    else if (out_taken) out_valid <= 1'b0;
  end

  assign out_free = !out_valid || out_taken;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (in_take) state_next = ST_SETUP;
      ST_SETUP: state_next = ST_FETCH;
      ST_FETCH: state_next = status.search_done ? ST_RED : ST_STEP;
      ST_STEP:  state_next = ST_FETCH;
      ST_RED:   state_next = ST_GREEN;
      ST_GREEN: state_next = ST_BLUE;
      ST_BLUE:  state_next = ST_OUT;
      ST_OUT:   if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd = '0;
    busy = 1'b1;
    case (state)
      ST_IDLE:  begin busy = 1'b0; cmd.load = in_take; end
      ST_SETUP: cmd.setup = 1'b1;
      ST_FETCH: cmd.fetch = !status.search_done;
      ST_STEP:  cmd.step = 1'b1;
      ST_RED:   begin cmd.chan_rd = 1'b1; cmd.chan_sel = CH_RED; end
      ST_GREEN: begin
        cmd.chan_rd = 1'b1;
        cmd.chan_sel = CH_GREEN;
        cmd.keep_red = 1'b1;
      end
      ST_BLUE:  begin
        cmd.chan_rd = 1'b1;
        cmd.chan_sel = CH_BLUE;
        cmd.keep_green = 1'b1;
      end
      ST_OUT:   cmd.publish = out_free;
      default:  busy = 1'b1;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/hwp_datapath.sv =====
// ----------------------------------------------------------------------------
// hwp_datapath
// scan counters, vector setup, hue search and channel lookup
// ----------------------------------------------------------------------------
`default_nettype none
module hwp_datapath import hwp_pkg::*; (
  input  wire              clk,
  input  wire              rst,
  input  wire [DimW-1:0]   frame_width,
  input  wire [DimW-1:0]   frame_height,
  input  wire              start_frame,
  input  hwp_cmd_t         cmd,
  output hwp_status_t      status,
  output logic [7:0]       red,
  output logic [7:0]       green,
  output logic [7:0]       blue,
  output logic             end_of_line,
  output logic             end_of_frame
);

  logic [CntW-1:0] column, row;
  logic [DimW-1:0] w, h;
  logic [CntW-1:0] col_eff, row_eff;
  logic [CntW-1:0] col_cur, row_cur;
  logic [DimW-1:0] wc, hc;
  logic            eol, eof;
  logic signed [ProdW-1:0] dx, dy;
  logic [ProdW-1:0] u, v;
  logic [1:0]       quad;
  logic             center;
  logic [QBits:0]   lo, hi;
  logic [QBits:0]   mid;
  logic [ProdW+BndW-1:0] lhs, rhs;
  logic [BndW-1:0]  bnd_rom [QSteps];
  logic [BndW-1:0]  sin_q, cos_q;
  logic [7:0]       chan_rom [ChanDepth];
  logic [7:0]       chan_q;
  logic             chan_zero_q;
  logic [AngBits-1:0] n;
  logic [PhW:0]     p_raw;
  logic [PhW-1:0]   p_wrap, p_fold;
  logic             chan_neg;
  logic [ChanIdxW-1:0] chan_idx;
  logic [7:0]       chan_lvl;
  logic [7:0]       red_w, green_w;

  // constant tables: sine of each half step boundary, level of each even phase
  initial begin
    for (int j = 0; j < QSteps; j++) bnd_rom[QBits'(j)] = quarter_sine(unsigned'(6 * j + 3));
    for (int i = 0; i < ChanDepth; i++) chan_rom[ChanIdxW'(i)] = chan_level(unsigned'(2 * i));
  end

  // clamp the frame size and restart the scan position on a new frame or outside it
  always_comb begin
    w = (frame_width == '0) ? DimW'(1) :
        (frame_width > DimW'(MaxDim)) ? DimW'(MaxDim) : frame_width;
    h = (frame_height == '0) ? DimW'(1) :
        (frame_height > DimW'(MaxDim)) ? DimW'(MaxDim) : frame_height;
    col_eff = start_frame ? '0 : column;
    row_eff = start_frame ? '0 : row;
    if ({1'b0, col_eff} >= w) col_eff = '0;
    if ({1'b0, row_eff} >= h) row_eff = '0;
  end

  // signed vector from the frame center (set up from latched pixel)
  always_comb begin
    dx = (ProdW'(signed'({1'b0, col_cur, 1'b0})) - ProdW'(signed'({1'b0, wc})))
         * ProdW'(signed'({1'b0, hc}));
    dy = (ProdW'(signed'({1'b0, hc})) - ProdW'(signed'({1'b0, row_cur, 1'b0})))
         * ProdW'(signed'({1'b0, wc}));
  end

  // latch the pixel, fold the vector into a quadrant, run the search
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      col_cur <= col_eff;
      row_cur <= row_eff;
      wc <= w;
      hc <= h;
      lo <= '0;
      hi <= (QBits + 1)'(QSteps);
      eol <= ({1'b0, col_eff} == w - 1'b1);
      eof <= ({1'b0, col_eff} == w - 1'b1) && ({1'b0, row_eff} == h - 1'b1);
    end
    if (cmd.setup) begin
      center <= (dx == '0) && (dy == '0);
      if (dx > 0 && dy >= 0) begin
        quad <= 2'd0; u <= dx; v <= dy;
      end else if (dx <= 0 && dy > 0) begin
        quad <= 2'd1; u <= dy; v <= -dx;
      end else if (dx < 0 && dy <= 0) begin
        quad <= 2'd2; u <= -dx; v <= -dy;
      end else begin
        quad <= 2'd3; u <= -dy; v <= dx;
      end
    end
    if (cmd.step) begin
      if (lhs >= rhs) lo <= mid + 1'b1;
      else hi <= mid;
    end
  end

  // boundary sine and cosine of the probe, cosine is the mirrored entry
  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      sin_q <= bnd_rom[mid[QBits-1:0]];
      cos_q <= bnd_rom[~mid[QBits-1:0]];
    end
  end

  // one comparison per search step
  always_comb begin
    mid = (lo + hi) >> 1;
    lhs = (ProdW + BndW)'(v) * (ProdW + BndW)'(cos_q);
    rhs = (ProdW + BndW)'(u) * (ProdW + BndW)'(sin_q);
    status.search_done = (lo >= hi);
  end

  // channel phase: six units per hue step plus a third of a turn per channel
  always_comb begin
    n = AngBits'({quad, {QBits{1'b0}}}) + AngBits'(lo);
    p_raw = (PhW + 1)'({n, 2'b00}) + (PhW + 1)'({n, 1'b0})
            + ((PhW + 1)'(cmd.chan_sel) << (AngBits + 1));
    p_wrap = (p_raw >= (PhW + 1)'(Fine)) ? PhW'(p_raw - (PhW + 1)'(Fine)) : PhW'(p_raw);
    chan_neg = (p_wrap >= PhW'(Fine / 2));
    p_fold = (p_wrap > PhW'(Fine / 4)) ? PhW'(Fine / 2) - p_wrap : p_wrap;
    chan_idx = chan_neg ? '0 : p_fold[ChanIdxW:1];
  end

  // channel level lookup, dark in the negative half wave and at the center
  always_ff @(posedge clk) begin
    if (cmd.chan_rd) begin
      chan_q <= chan_rom[chan_idx];
      chan_zero_q <= chan_neg || center;
    end
  end

  assign chan_lvl = chan_zero_q ? 8'd0 : chan_q;

  // collect the channels, then load the result register
  always_ff @(posedge clk) begin
    if (cmd.keep_red) red_w <= chan_lvl;
    if (cmd.keep_green) green_w <= chan_lvl;
    if (cmd.publish) begin
      red <= red_w;
      green <= green_w;
      blue <= chan_lvl;
      end_of_line <= eol;
      end_of_frame <= eof;
    end
  end

  // scan advance
  always_ff @(posedge clk) begin
    if (rst) begin
      column <= '0;
      row <= '0;
    end else if (cmd.setup) begin
      if (eol) begin
        column <= '0;
        row <= eof ? '0 : row_cur + 1'b1;
      end else begin
        column <= col_cur + 1'b1;
        row <= row_cur;
      end
    end
  end

endmodule
`default_nettype wire

// ===== test/hue_wheel_pattern_generator_unit_tb.sv =====
// ----------------------------------------------------------------------------
// hue_wheel_pattern_generator_unit_tb
// self-checking bench for the hue wheel pattern generator: a scoreboard
// predicts every pixel in fixed point and compares each output transaction,
// while frame sizes, start flags and bus idling vary from phase to phase
// ----------------------------------------------------------------------------
`default_nettype none

typedef struct {
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;
  logic       eol;
  logic       eof;
} pixel_t;

// pixel predictor and store of expected pixels
class hue_wheel_scoreboard;
  pixel_t       expected_pixels[$];
  int unsigned  frame_w = 640;
  int unsigned  frame_h = 480;
  int unsigned  col = 0;
  int unsigned  row = 0;
  int           mismatches = 0;

  // taylor sine in q30 of a phase within a quarter turn
  function longint sine_q30(longint unsigned p);
    longint unsigned x, x2, term;
    longint s;
    x = (p * 64'd6746518852) / 64'd24576;
    x2 = (x * x) >> 30;
    term = x;
    s = longint'(x);
    for (int i = 1; i <= 8; i++) begin
      term = ((term * x2) >> 30) / longint'((2 * i) * (2 * i + 1));
      if (i % 2) s -= longint'(term);
      else s += longint'(term);
    end
    if (s < 0) s = 0;
    if (s > (longint'(1) << 30)) s = longint'(1) << 30;
    return s;
  endfunction

  // positive half wave of the sine, scaled to 0..255
  function logic [7:0] channel_level(longint unsigned p);
    longint unsigned v;
    p = p % 24576;
    if (p >= 12288) return 8'd0;
    if (p > 6144) p = 12288 - p;
    v = (longint'(sine_q30(p)) * 255 + (1 << 14)) >> 30;
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  // rounded hue angle in 12-bit turns for a nonzero vector
  function longint unsigned hue_angle(longint dx, longint dy);
    longint unsigned q, u, v, lo, hi, mid, b;
    lo = 0;
    hi = 1024;
    if (dx > 0 && dy >= 0) begin
      q = 0; u = dx; v = dy;
    end else if (dx <= 0 && dy > 0) begin
      q = 1; u = dy; v = -dx;
    end else if (dx < 0 && dy <= 0) begin
      q = 2; u = -dx; v = -dy;
    end else begin
      q = 3; u = -dy; v = dx;
    end
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      b = 6 * mid + 3;
      if (v * sine_q30(6144 - b) >= u * sine_q30(b)) lo = mid + 1;
      else hi = mid;
    end
    return (q * 1024 + lo) & 64'hFFF;
  endfunction

  function int unsigned usable_dim(int unsigned d);
    if (d == 0) return 1;
    return (d > 4096) ? 4096 : d;
  endfunction

  // accepted input transaction: predict its pixel and advance the scan
  function void note_input(bit start_frame);
    pixel_t px;
    int unsigned w, h;
    longint dx, dy;
    longint unsigned base;
    w = usable_dim(frame_w);
    h = usable_dim(frame_h);
    if (start_frame) begin
      col = 0;
      row = 0;
    end
    if (col >= w) col = 0;
    if (row >= h) row = 0;
    dx = (2 * longint'(col) - longint'(w)) * longint'(h);
    dy = (longint'(h) - 2 * longint'(row)) * longint'(w);
    if (dx == 0 && dy == 0) begin
      px.red = 0; px.green = 0; px.blue = 0;
    end else begin
      base = 6 * hue_angle(dx, dy);
      px.red = channel_level(base);
      px.green = channel_level(base + 8192);
      px.blue = channel_level(base + 16384);
    end
    px.alpha = 8'd255;
    px.eol = (col == w - 1);
    px.eof = px.eol && (row == h - 1);
    if (px.eol) begin
      col = 0;
      row = px.eof ? 0 : row + 1;
    end else begin
      col++;
    end
    expected_pixels.push_back(px);
  endfunction

  // output transaction: compare with the oldest prediction
  function void check_pixel(logic [31:0] data, logic last, logic user);
    pixel_t px;
    if (expected_pixels.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected pixel %h", data);
      return;
    end
    px = expected_pixels.pop_front();
    if (data !== {px.alpha, px.blue, px.green, px.red} || last !== px.eol
        || user !== px.eof) begin
      mismatches++;
      if (mismatches <= 10)
        $display("pixel mismatch: expected rgba %h eol %b eof %b, got %h eol %b eof %b",
                 {px.alpha, px.blue, px.green, px.red}, px.eol, px.eof, data, last, user);
    end
  endfunction
endclass

module hue_wheel_pattern_generator_unit_tb;
  import hwp_pkg::*;

  localparam int StallLimit = 5000;

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_we = 0;
  logic        cfg_index = 0;
  logic [12:0] cfg_data = 0;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [7:0]  s_tdata = 0;   // [0] start_frame
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [31:0] m_tdata;       // red, green, blue, alpha
  logic        m_tlast;       // end_of_line
  logic        m_tuser;       // end_of_frame

  int src_idle_pct = 0;
  int snk_stall_pct = 0;
  int quiet_cycles = 0;
  hue_wheel_scoreboard sb = new();

  hue_wheel_pattern_generator_unit DUT (.*);

  always #5 clk = ~clk;

  // receiver with random stalls, plus the watchdog
  always @(posedge clk) begin
    if (m_tvalid && m_tready) sb.check_pixel(m_tdata, m_tlast, m_tuser);
    if (!rst) begin
      if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
    m_tready <= ($urandom_range(99) >= snk_stall_pct);
  end

  // one input transaction, with an optional idle gap first
  task automatic send_pixel(bit start_frame);
    if ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    s_tvalid <= 1;
    s_tdata <= {7'd0, start_frame};
    do @(posedge clk); while (!s_tready);
    sb.note_input(start_frame);
  endtask

  // frame size change once the block has drained
  task automatic set_frame(int unsigned w, int unsigned h);
    s_tvalid <= 0;
    @(posedge clk);
    while (sb.expected_pixels.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_we <= 1;
    cfg_index <= 0;
    cfg_data <= w[12:0];
    @(posedge clk);
    cfg_index <= 1;
    cfg_data <= h[12:0];
    @(posedge clk);
    cfg_we <= 0;
    sb.frame_w = w[12:0];
    sb.frame_h = h[12:0];
  endtask

  function automatic int unsigned pick_dim();
    case ($urandom_range(9))
      0: return 0;
      1: return 4096;
      2: return 8191;
      3: return $urandom_range(8191);
      default: return $urandom_range(1, 12);
    endcase
  endfunction

  initial begin
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: reset size, then a full small frame through the center pixel
    send_pixel(1);
    send_pixel(0);
    send_pixel(0);
    set_frame(4, 4);
    send_pixel(1);
    repeat (15) send_pixel(0);
    // zero size and oversize
    set_frame(0, 0);
    send_pixel(0);
    send_pixel(1);
    set_frame(8191, 4096);
    send_pixel(0);
    send_pixel(0);

    // random phases; shrinking sizes leave the counters beyond the frame
    for (int ph = 0; ph < 12; ph++) begin
      case (ph % 4)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 74; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 74; end
        default: begin src_idle_pct = 26; snk_stall_pct = 26; end
      endcase
      set_frame(pick_dim(), pick_dim());
      repeat (48) send_pixel($urandom_range(19) == 0);
    end

    s_tvalid <= 0;
    @(posedge clk);
    while (sb.expected_pixels.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (sb.mismatches == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

`default_nettype wire
